/* design/jsfe_pkg.sv */
// ============================================================================
// JSON string field extractor package
// Shared types, character codes and helper functions for the extractor core.
// ============================================================================
`default_nettype none

package jsfe_pkg;

    // Scan phases of the extractor.
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_SPACE,
        PH_VALUE,
        PH_ESCAPE,
        PH_HEX,
        PH_DONE
    } t_phase;

    // Result kinds.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_BYTE = 2'd0;
    localparam t_kind KIND_DONE = 2'd1;
    localparam t_kind KIND_FAIL = 2'd2;

    // Configuration register indexes.
    typedef logic t_cfg_index;
    localparam t_cfg_index CFG_KEY_BYTES  = 1'b0;
    localparam t_cfg_index CFG_KEY_LENGTH = 1'b1;

    // Reset values of the configuration registers (key "text", four characters).
    localparam logic [63:0] KEY_BYTES_RESET  = 64'd1954047348;
    localparam logic [3:0]  KEY_LENGTH_RESET = 4'd4;

    // One input byte gives at most four results.
    localparam int MAX_RES   = 4;
    localparam int RES_CNT_W = 3;

    // One result word as held in the output buffer.
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_result;

    // UTF-8 encoding of one code point; byte 0 goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } t_utf8;

    // Character codes.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LF     = 8'h0a;

    // Surrogate ranges and the supplementary plane base.
    localparam logic [15:0] SURR_HIGH_FIRST = 16'hd800;
    localparam logic [15:0] SURR_HIGH_LAST  = 16'hdbff;
    localparam logic [5:0]  SURR_HIGH_TAG   = 6'b110110;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;
    localparam logic [3:0]  HEX_D           = 4'hd;
    localparam logic [3:0]  HEX_C           = 4'hc;

    // Hex digit decode: bit 4 is set when the character is a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // UTF-8 encoding of a code point of up to 21 bits.
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp <= 21'h7f) begin
            r.bytes[0] = cp[7:0];
            r.count    = 3'd1;
        end else if (cp <= 21'h7ff) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.count    = 3'd2;
        end else if (cp <= 21'hffff) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.count    = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.count    = 3'd4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/json_string_field_extractor_core.sv */
// A byte accepted into the input stage is decoded there, and its results are registered
// in the result buffer, from which the first is offered on the output.
// Throughput: one byte per cycle while each byte gives at most one result and output is
// not stalled; more results hold the four-entry result buffer until taken, and input waits.
// Reset is synchronous and active low: it clears the scan to the searching phase,
// empties the input and result stages and loads the key "text" with length four.
// ============================================================================
// JSON string field extractor core
// Scans a JSON document byte by byte for a quoted key and streams the decoded
// UTF-8 bytes of its string value, followed by a completion or failure word.
// ============================================================================
`default_nettype none

module json_string_field_extractor_core #(
    parameter int MAX_KEY_BYTES = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Configuration write port.
    input  wire logic                    i_cfg_wr_en,
    input  wire jsfe_pkg::t_cfg_index    i_cfg_index,
    input  wire logic [63:0]             i_cfg_data,
    // Input channel.
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [7:0]              i_in_byte,
    input  wire logic                    i_end_of_document,
    // Output channel.
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [7:0]                   o_out_byte,
    output jsfe_pkg::t_kind              o_kind,
    output logic                         o_last
);

    localparam int WIN_DEPTH = MAX_KEY_BYTES + 2;
    localparam int KEY_W     = MAX_KEY_BYTES * 8;

    // Configuration registers.
    logic [KEY_W-1:0] r_key_bytes;
    logic [3:0]       r_key_len;
    logic [3:0]       key_len_sat;

    // Input stage and skid stage.
    logic       r_in_valid, r_sk_valid;
    logic [7:0] r_in_byte,  r_sk_byte;
    logic       r_in_eod,   r_sk_eod;
    logic       in_take;

    // Scan state.
    jsfe_pkg::t_phase                r_phase, n_phase;
    logic [WIN_DEPTH-1:0][7:0]       r_win, n_win;
    logic [15:0]                     r_acc, n_acc;
    logic [2:0]                      r_hcnt, n_hcnt;
    logic [9:0]                      r_pend, n_pend;
    logic                            r_pend_valid, n_pend_valid;

    // Result buffer.
    jsfe_pkg::t_result [jsfe_pkg::MAX_RES-1:0] r_res, n_res;
    logic [jsfe_pkg::RES_CNT_W-1:0]            r_res_cnt, n_res_cnt;
    logic                                      out_take;
    logic                                      load;

    // Decode helpers.
    logic             key_hit;
    logic [4:0]       hd;
    logic [15:0]      acc_next;
    logic [2:0]       hcnt_next;
    logic [20:0]      main_cp;
    jsfe_pkg::t_utf8  main_enc;
    jsfe_pkg::t_utf8  flush_enc;
    logic             main_use_cp;
    logic             main_byte_valid;
    logic [7:0]       main_byte;
    logic             main_done;
    logic             do_flush;
    logic             do_fail;

    // Key length above the supported maximum saturates.
    assign key_len_sat = (r_key_len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : r_key_len;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= jsfe_pkg::KEY_BYTES_RESET[KEY_W-1:0];
            r_key_len   <= jsfe_pkg::KEY_LENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                jsfe_pkg::CFG_KEY_BYTES: begin
                    r_key_bytes <= i_cfg_data[KEY_W-1:0];
                end
                jsfe_pkg::CFG_KEY_LENGTH: begin
                    r_key_len <= i_cfg_data[3:0];
                end
                default: begin
                    r_key_len <= r_key_len;
                end
            endcase
        end
    end

    // Handshakes: the skid stage fills only while the input stage is held.
    assign o_stall  = r_sk_valid;
    assign in_take  = i_valid && !r_sk_valid;
    assign o_valid  = (r_res_cnt != '0);
    assign out_take = o_valid && !i_stall;
    assign load     = r_in_valid &&
                      ((r_res_cnt == '0) || ((r_res_cnt == 3'd1) && out_take));

    // Input and skid stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (load || !r_in_valid) begin
            r_in_valid <= r_sk_valid || in_take;
            r_sk_valid <= 1'b0;
        end else if (in_take) begin
            r_sk_valid <= 1'b1;
        end
    end

    // Input and skid stage words.
    always_ff @(posedge i_clk) begin
        if (load || !r_in_valid) begin
            if (r_sk_valid) begin
                r_in_byte <= r_sk_byte;
                r_in_eod  <= r_sk_eod;
            end else begin
                r_in_byte <= i_in_byte;
                r_in_eod  <= i_end_of_document;
            end
        end else if (in_take) begin
            r_sk_byte <= i_in_byte;
            r_sk_eod  <= i_end_of_document;
        end
    end

    // Key match on the shifted window, one compare row per possible key length.
    always_comb begin
        logic m;
        n_win   = {r_win[WIN_DEPTH-2:0], r_in_byte};
        key_hit = 1'b0;
        for (int l = 0; l <= MAX_KEY_BYTES; l++) begin
            m = (n_win[0] == jsfe_pkg::CH_QUOTE) && (n_win[l+1] == jsfe_pkg::CH_QUOTE);
            for (int j = 0; j < MAX_KEY_BYTES; j++) begin
                if (j < l) begin
                    m = m && (n_win[l-j] == r_key_bytes[8*j +: 8]);
                end
            end
            if (key_len_sat == 4'(l)) begin
                key_hit = m;
            end
        end
    end

    // Hex digit accumulation and code point selection.
    assign hd        = jsfe_pkg::hex_digit(r_in_byte);
    assign acc_next  = {r_acc[11:0], hd[3:0]};
    assign hcnt_next = r_hcnt + 3'd1;
    assign main_cp   = r_pend_valid ?
                       (jsfe_pkg::SUPP_BASE + {1'b0, r_pend, acc_next[9:0]}) :
                       {5'd0, acc_next};
    assign main_enc  = jsfe_pkg::utf8_encode(main_cp);
    assign flush_enc = jsfe_pkg::utf8_encode({5'd0, jsfe_pkg::SURR_HIGH_TAG, r_pend});

    // Next scan state and the results of the byte in the input stage.
    always_comb begin
        n_phase         = r_phase;
        n_acc           = r_acc;
        n_hcnt          = r_hcnt;
        n_pend          = r_pend;
        n_pend_valid    = r_pend_valid;
        do_flush        = 1'b0;
        do_fail         = 1'b0;
        main_use_cp     = 1'b0;
        main_byte_valid = 1'b0;
        main_byte       = r_in_byte;
        main_done       = 1'b0;

        case (r_phase)
            jsfe_pkg::PH_SEARCH: begin
                if (key_hit) begin
                    n_phase = jsfe_pkg::PH_COLON;
                end
            end
            jsfe_pkg::PH_COLON: begin
                if (r_in_byte == jsfe_pkg::CH_COLON) begin
                    n_phase = jsfe_pkg::PH_SPACE;
                end
            end
            jsfe_pkg::PH_SPACE: begin
                if (r_in_byte == jsfe_pkg::CH_SPACE ||
                    (r_in_byte >= jsfe_pkg::CH_TAB && r_in_byte <= jsfe_pkg::CH_CR)) begin
                    n_phase = jsfe_pkg::PH_SPACE;
                end else if (r_in_byte == jsfe_pkg::CH_QUOTE) begin
                    n_phase = jsfe_pkg::PH_VALUE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            jsfe_pkg::PH_VALUE: begin
                if (r_in_byte == jsfe_pkg::CH_QUOTE) begin
                    do_flush  = r_pend_valid;
                    main_done = 1'b1;
                    n_phase   = jsfe_pkg::PH_DONE;
                end else if (r_in_byte == jsfe_pkg::CH_BSLASH) begin
                    n_phase = jsfe_pkg::PH_ESCAPE;
                end else begin
                    do_flush        = r_pend_valid;
                    main_byte_valid = 1'b1;
                end
            end
            jsfe_pkg::PH_ESCAPE: begin
                n_phase         = jsfe_pkg::PH_VALUE;
                do_flush        = r_pend_valid;
                main_byte_valid = 1'b1;
                case (r_in_byte)
                    jsfe_pkg::CH_LC_U: begin
                        n_acc           = '0;
                        n_hcnt          = '0;
                        n_phase         = jsfe_pkg::PH_HEX;
                        do_flush        = 1'b0;
                        main_byte_valid = 1'b0;
                    end
                    jsfe_pkg::CH_QUOTE:  main_byte = jsfe_pkg::CH_QUOTE;
                    jsfe_pkg::CH_BSLASH: main_byte = jsfe_pkg::CH_BSLASH;
                    jsfe_pkg::CH_SLASH:  main_byte = jsfe_pkg::CH_SLASH;
                    jsfe_pkg::CH_LC_B:   main_byte = jsfe_pkg::CH_BS;
                    jsfe_pkg::CH_LC_F:   main_byte = jsfe_pkg::CH_FF;
                    jsfe_pkg::CH_LC_N:   main_byte = jsfe_pkg::CH_LF;
                    jsfe_pkg::CH_LC_R:   main_byte = jsfe_pkg::CH_CR;
                    jsfe_pkg::CH_LC_T:   main_byte = jsfe_pkg::CH_TAB;
                    default: begin
                        do_fail = 1'b1;
                    end
                endcase
            end
            jsfe_pkg::PH_HEX: begin
                if (!hd[4]) begin
                    do_fail = 1'b1;
                end else begin
                    n_acc  = acc_next;
                    n_hcnt = hcnt_next;
                    // A pending high surrogate goes out alone once the escape
                    // cannot be a low surrogate.
                    if (r_pend_valid &&
                        ((hcnt_next == 3'd1 && hd[3:0] != jsfe_pkg::HEX_D) ||
                         (hcnt_next == 3'd2 && hd[3:0] < jsfe_pkg::HEX_C))) begin
                        do_flush     = 1'b1;
                        n_pend_valid = 1'b0;
                        n_pend       = '0;
                    end
                    if (hcnt_next == 3'd4) begin
                        if (r_pend_valid) begin
                            main_use_cp  = 1'b1;
                            n_pend_valid = 1'b0;
                            n_pend       = '0;
                        end else if (acc_next >= jsfe_pkg::SURR_HIGH_FIRST &&
                                     acc_next <= jsfe_pkg::SURR_HIGH_LAST) begin
                            n_pend       = acc_next[9:0];
                            n_pend_valid = 1'b1;
                        end else begin
                            main_use_cp = 1'b1;
                        end
                        n_acc   = '0;
                        n_hcnt  = '0;
                        n_phase = jsfe_pkg::PH_VALUE;
                    end
                end
            end
            default: begin
                n_phase = jsfe_pkg::PH_DONE;
            end
        endcase

        // Pending surrogate is released by the escapes and characters above.
        if (do_flush) begin
            n_pend_valid = 1'b0;
            n_pend       = '0;
        end

        if (do_fail) begin
            n_phase      = jsfe_pkg::PH_DONE;
            n_pend_valid = 1'b0;
            n_pend       = '0;
            n_acc        = '0;
            n_hcnt       = '0;
        end

        // The final byte of a document fails an unfinished scan and restarts.
        if (r_in_eod) begin
            if (n_phase != jsfe_pkg::PH_DONE) begin
                do_fail = 1'b1;
            end
            n_phase      = jsfe_pkg::PH_SEARCH;
            n_pend_valid = 1'b0;
            n_pend       = '0;
            n_acc        = '0;
            n_hcnt       = '0;
        end
    end

    // Result list: a failure word alone, or an optional flushed surrogate, then the byte's own results.
    always_comb begin
        n_res     = '0;
        n_res_cnt = '0;
        if (do_fail) begin
            n_res[0]  = '{data: 8'd0, kind: jsfe_pkg::KIND_FAIL};
            n_res_cnt = 3'd1;
        end else if (do_flush) begin
            for (int k = 0; k < 3; k++) begin
                n_res[k] = '{data: flush_enc.bytes[k], kind: jsfe_pkg::KIND_BYTE};
            end
            n_res_cnt = 3'd3;
            if (main_done) begin
                n_res[3]  = '{data: 8'd0, kind: jsfe_pkg::KIND_DONE};
                n_res_cnt = 3'd4;
            end else if (main_byte_valid) begin
                n_res[3]  = '{data: main_byte, kind: jsfe_pkg::KIND_BYTE};
                n_res_cnt = 3'd4;
            end
        end else if (main_done) begin
            n_res[0]  = '{data: 8'd0, kind: jsfe_pkg::KIND_DONE};
            n_res_cnt = 3'd1;
        end else if (main_byte_valid) begin
            n_res[0]  = '{data: main_byte, kind: jsfe_pkg::KIND_BYTE};
            n_res_cnt = 3'd1;
        end else if (main_use_cp) begin
            for (int k = 0; k < jsfe_pkg::MAX_RES; k++) begin
                n_res[k] = '{data: main_enc.bytes[k], kind: jsfe_pkg::KIND_BYTE};
            end
            n_res_cnt = main_enc.count;
        end
    end

    // Scan state registers, updated when a byte is decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= jsfe_pkg::PH_SEARCH;
            r_win        <= '0;
            r_acc        <= '0;
            r_hcnt       <= '0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
        end else if (load) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_hcnt       <= n_hcnt;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            if (r_in_eod) begin
                r_win <= '0;
            end else if (r_phase == jsfe_pkg::PH_SEARCH) begin
                r_win <= n_win;
            end
        end
    end

    // Result buffer count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= '0;
        end else if (load) begin
            r_res_cnt <= n_res_cnt;
        end else if (out_take) begin
            r_res_cnt <= r_res_cnt - 3'd1;
        end
    end

    // Result buffer words: loaded on decode, shifted down as words leave.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end else if (out_take) begin
            for (int k = 0; k < jsfe_pkg::MAX_RES - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

    assign o_out_byte = r_res[0].data;
    assign o_kind     = r_res[0].kind;
    assign o_last     = (r_res_cnt == 3'd1);

    // A completion or failure word always closes the results of its byte.
    a_end_word_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == jsfe_pkg::KIND_DONE || o_kind == jsfe_pkg::KIND_FAIL))
        |-> o_last)
        else $error("completion or failure word not marked last");

    // The skid stage only holds a byte behind a held input stage.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_in_valid)
        else $error("skid stage full while input stage empty");

    // A held high surrogate exists only inside the string value.
    a_pend_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_phase == jsfe_pkg::PH_VALUE ||
                          r_phase == jsfe_pkg::PH_ESCAPE ||
                          r_phase == jsfe_pkg::PH_HEX))
        else $error("pending surrogate outside the value");

    // A decoded byte never leaves more results than the buffer holds.
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_res_cnt <= 3'(jsfe_pkg::MAX_RES)))
        else $error("result count beyond buffer depth");

endmodule

`default_nettype wire

/* bench/json_string_field_extractor_core_test.sv */
// ============================================================================
// JSON string field extractor core testbench
// Drives JSON documents byte by byte under random input gaps and output
// stalls. A scoreboard class tracks the key search and the string decoding to
// predict every UTF-8 byte, completion and failure word, and checks each
// accepted output word against the oldest prediction.
// ============================================================================

module json_string_field_extractor_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 6;
    localparam int PRINT_LIMIT     = 40;

    // Character codes the scan reacts to.
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5c;
    localparam logic [7:0] C_SLASH  = 8'h2f;
    localparam logic [7:0] C_COLON  = 8'h3a;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LC_U   = 8'h75;
    localparam logic [7:0] C_LC_B   = 8'h62;
    localparam logic [7:0] C_LC_F   = 8'h66;
    localparam logic [7:0] C_LC_N   = 8'h6e;
    localparam logic [7:0] C_LC_R   = 8'h72;
    localparam logic [7:0] C_LC_T   = 8'h74;

    // Surrogate ranges.
    localparam logic [15:0] HIGH_FIRST = 16'hd800;
    localparam logic [15:0] HIGH_LAST  = 16'hdbff;
    localparam logic [15:0] LOW_FIRST  = 16'hdc00;

    // One output word as the scoreboard expects it.
    typedef struct {
        logic [7:0]      data;
        jsfe_pkg::t_kind kind;
        logic            last;
    } t_utf8_word;

    // ------------------------------------------------------------------------
    // Scoreboard: follows the scan and decoding state of the block and holds
    // the words still to come out.
    // ------------------------------------------------------------------------
    class extract_scoreboard;
        logic [63:0]      key_chars;
        logic [3:0]       key_len;
        jsfe_pkg::t_phase phase;
        logic [7:0]       window [10];
        logic [15:0]      hex_acc;
        logic [2:0]       hex_cnt;
        logic [9:0]       high_half;
        logic             high_held;
        t_utf8_word       step_words [$];
        t_utf8_word       words_due [$];
        int               mismatches;

        function new();
            key_chars  = jsfe_pkg::KEY_BYTES_RESET;
            key_len    = jsfe_pkg::KEY_LENGTH_RESET;
            mismatches = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            phase = jsfe_pkg::PH_SEARCH;
            foreach (window[k]) window[k] = 8'h00;
            hex_acc   = '0;
            hex_cnt   = '0;
            high_half = '0;
            high_held = 1'b0;
        endfunction

        function void set_register(jsfe_pkg::t_cfg_index idx, logic [63:0] value);
            if (idx == jsfe_pkg::CFG_KEY_BYTES) begin
                key_chars = value;
            end else if (idx == jsfe_pkg::CFG_KEY_LENGTH) begin
                key_len = value[3:0];
            end
        endfunction

        function void put(logic [7:0] data, jsfe_pkg::t_kind kind);
            t_utf8_word w;
            w.data = data;
            w.kind = kind;
            w.last = 1'b0;
            step_words.insert(step_words.size(), w);
        endfunction

        // A failure replaces whatever this byte would otherwise have produced.
        function void abort();
            step_words.delete();
            put(8'h00, jsfe_pkg::KIND_FAIL);
            phase     = jsfe_pkg::PH_DONE;
            high_held = 1'b0;
            high_half = '0;
            hex_cnt   = '0;
            hex_acc   = '0;
        endfunction

        function void encode(logic [20:0] cp);
            if (cp <= 21'h7f) begin
                put(cp[7:0], jsfe_pkg::KIND_BYTE);
            end else if (cp <= 21'h7ff) begin
                put(8'hc0 | 8'(cp >> 6), jsfe_pkg::KIND_BYTE);
                put(8'h80 | 8'(cp & 21'h3f), jsfe_pkg::KIND_BYTE);
            end else if (cp <= 21'hffff) begin
                put(8'he0 | 8'(cp >> 12), jsfe_pkg::KIND_BYTE);
                put(8'h80 | 8'((cp >> 6) & 21'h3f), jsfe_pkg::KIND_BYTE);
                put(8'h80 | 8'(cp & 21'h3f), jsfe_pkg::KIND_BYTE);
            end else begin
                put(8'hf0 | 8'((cp >> 18) & 21'h07), jsfe_pkg::KIND_BYTE);
                put(8'h80 | 8'((cp >> 12) & 21'h3f), jsfe_pkg::KIND_BYTE);
                put(8'h80 | 8'((cp >> 6) & 21'h3f), jsfe_pkg::KIND_BYTE);
                put(8'h80 | 8'(cp & 21'h3f), jsfe_pkg::KIND_BYTE);
            end
        endfunction

        // A held high surrogate that finds no partner goes out on its own.
        function void release_high();
            if (high_held) begin
                encode(21'(HIGH_FIRST) + 21'(high_half));
                high_held = 1'b0;
                high_half = '0;
            end
        endfunction

        function int hex_of(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
            return -1;
        endfunction

        function bit key_hit();
            int n;
            n = (key_len > 4'd8) ? 8 : int'(key_len);
            if (window[0] != C_QUOTE || window[n + 1] != C_QUOTE) return 1'b0;
            for (int j = 0; j < n; j++) begin
                if (window[n - j] != key_chars[8 * j +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_escape(logic [7:0] b);
            logic [7:0] v;
            if (b == C_LC_U) begin
                hex_acc = '0;
                hex_cnt = '0;
                phase   = jsfe_pkg::PH_HEX;
                return;
            end
            case (b)
                C_QUOTE:  v = C_QUOTE;
                C_BSLASH: v = C_BSLASH;
                C_SLASH:  v = C_SLASH;
                C_LC_B:   v = 8'h08;
                C_LC_F:   v = 8'h0c;
                C_LC_N:   v = 8'h0a;
                C_LC_R:   v = 8'h0d;
                C_LC_T:   v = 8'h09;
                default: begin
                    abort();
                    return;
                end
            endcase
            release_high();
            put(v, jsfe_pkg::KIND_BYTE);
            phase = jsfe_pkg::PH_VALUE;
        endfunction

        function void take_hex(logic [7:0] b);
            int          d;
            logic [31:0] cp;
            d = hex_of(b);
            if (d < 0) begin
                abort();
                return;
            end
            hex_acc = {hex_acc[11:0], 4'(d)};
            hex_cnt = hex_cnt + 3'd1;
            // The first digit must be d and the second c to f for a low surrogate.
            if (high_held && ((hex_cnt == 3'd1 && d != 'hd) || (hex_cnt == 3'd2 && d < 'hc))) begin
                release_high();
            end
            if (hex_cnt < 3'd4) return;
            if (high_held) begin
                cp = 32'h10000 + (32'(high_half) << 10) + (32'(hex_acc) - 32'(LOW_FIRST));
                high_held = 1'b0;
                high_half = '0;
                encode(cp[20:0]);
            end else if (hex_acc >= HIGH_FIRST && hex_acc <= HIGH_LAST) begin
                high_half = 10'(hex_acc - HIGH_FIRST);
                high_held = 1'b1;
            end else begin
                encode(21'(hex_acc));
            end
            hex_acc = '0;
            hex_cnt = '0;
            phase   = jsfe_pkg::PH_VALUE;
        endfunction

        // Works out the words caused by one accepted document byte.
        function void note_byte(logic [7:0] b, logic eod);
            t_utf8_word w;
            step_words.delete();
            case (phase)
                jsfe_pkg::PH_SEARCH: begin
                    for (int k = 9; k > 0; k--) window[k] = window[k - 1];
                    window[0] = b;
                    if (key_hit()) phase = jsfe_pkg::PH_COLON;
                end
                jsfe_pkg::PH_COLON: begin
                    if (b == C_COLON) phase = jsfe_pkg::PH_SPACE;
                end
                jsfe_pkg::PH_SPACE: begin
                    if (b == C_QUOTE) begin
                        phase = jsfe_pkg::PH_VALUE;
                    end else if (!(b == C_SPACE || (b >= 8'h09 && b <= 8'h0d))) begin
                        abort();
                    end
                end
                jsfe_pkg::PH_VALUE: begin
                    if (b == C_QUOTE) begin
                        release_high();
                        put(8'h00, jsfe_pkg::KIND_DONE);
                        phase = jsfe_pkg::PH_DONE;
                    end else if (b == C_BSLASH) begin
                        phase = jsfe_pkg::PH_ESCAPE;
                    end else begin
                        release_high();
                        put(b, jsfe_pkg::KIND_BYTE);
                    end
                end
                jsfe_pkg::PH_ESCAPE: take_escape(b);
                jsfe_pkg::PH_HEX:    take_hex(b);
                default:             phase = jsfe_pkg::PH_DONE;
            endcase
            if (eod) begin
                if (phase != jsfe_pkg::PH_DONE) abort();
                clear_scan();
            end
            foreach (step_words[k]) begin
                w      = step_words[k];
                w.last = (k == step_words.size() - 1);
                words_due.insert(words_due.size(), w);
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_word(logic [7:0] data, jsfe_pkg::t_kind kind, logic last);
            t_utf8_word w;
            if (words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word data %h kind %0d last %b",
                                          data, kind, last));
                return;
            end
            w = words_due.pop_front();
            if (data !== w.data)
                report_mismatch($sformatf("data %h, expected %h", data, w.data));
            if (kind !== w.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", kind, w.kind));
            if (last !== w.last)
                report_mismatch($sformatf("last %b, expected %b", last, w.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its signals.
    // ------------------------------------------------------------------------
    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_wr_en       = 1'b0;
    jsfe_pkg::t_cfg_index i_cfg_index       = jsfe_pkg::CFG_KEY_BYTES;
    logic [63:0]          i_cfg_data        = '0;
    logic                 i_valid           = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_in_byte         = '0;
    logic                 i_end_of_document = 1'b0;
    logic                 o_valid;
    logic                 i_stall           = 1'b0;
    logic [7:0]           o_out_byte;
    jsfe_pkg::t_kind      o_kind;
    logic                 o_last;

    json_string_field_extractor_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .i_end_of_document(i_end_of_document),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_kind           (o_kind),
        .o_last           (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    extract_scoreboard sb = new();

    // Stimulus state shared by the driving tasks.
    logic [7:0]  doc_bytes [$];
    logic [63:0] cur_key       = 64'h74786574;
    logic [3:0]  cur_len       = 4'd4;
    int          send_gap_pct  = 0;
    int          stall_pct     = 0;
    bit          hold_off_req  = 1'b0;
    int          bytes_sent    = 0;
    string       lead_chars    = "{ ,a\"";
    string       trail_chars   = "}, \n";
    string       esc_chars     = "\"\\/bfnrt";
    string       bad_esc_chars = "aqxU0' ";
    string       bad_hex_chars = "gGxz \"";

    // ------------------------------------------------------------------------
    // Monitor: every handshake is sampled at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) sb.set_register(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) sb.note_byte(i_in_byte, i_end_of_document);
            if (o_valid && !i_stall) sb.check_word(o_out_byte, o_kind, o_last);
        end
    end

    // Result side: random stall bursts, and one long hold-off on request.
    initial begin : result_sink
        int burst;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                burst = $urandom_range(1, 13);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Ends the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("json_string_field_extractor_core_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks.
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic eod);
        if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_in_byte         <= b;
        i_end_of_document <= eod;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Sends the built document; the final byte carries the end marker.
    task automatic send_doc();
        for (int k = 0; k < doc_bytes.size(); k++) begin
            send_byte(doc_bytes[k], k == doc_bytes.size() - 1);
        end
        doc_bytes.delete();
    endtask

    // Waits until every expected word is out and the block has settled.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.words_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(jsfe_pkg::t_cfg_index idx, logic [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_key(logic [63:0] chars, logic [63:0] len_word);
        drain_results();
        write_reg(jsfe_pkg::CFG_KEY_BYTES, chars);
        write_reg(jsfe_pkg::CFG_KEY_LENGTH, len_word);
        cur_key = chars;
        cur_len = len_word[3:0];
    endtask

    function automatic logic [63:0] letters();
        logic [63:0] r;
        for (int k = 0; k < 8; k++) r[8 * k +: 8] = 8'($urandom_range('h61, 'h7a));
        return r;
    endfunction

    // Appends one byte to the document being built.
    function automatic void add_byte(logic [7:0] b);
        doc_bytes.insert(doc_bytes.size(), b);
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endfunction

    // Quoted key as the block currently expects it.
    function automatic void add_key();
        int n;
        n = (cur_len > 4'd8) ? 8 : int'(cur_len);
        add_byte(C_QUOTE);
        for (int j = 0; j < n; j++) add_byte(cur_key[8 * j +: 8]);
        add_byte(C_QUOTE);
    endfunction

    // A \u escape with a random mix of digit cases.
    function automatic void add_u(logic [15:0] v);
        logic [3:0] nib;
        add_byte(C_BSLASH);
        add_byte(C_LC_U);
        for (int k = 3; k >= 0; k--) begin
            nib = v[4 * k +: 4];
            if (nib < 4'd10) begin
                add_byte(8'h30 + 8'(nib));
            end else begin
                add_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
            end
        end
    endfunction

    // One element of a string value, or a broken escape.
    function automatic void add_piece(bit broken);
        logic [7:0] c;
        if (broken) begin
            add_byte(C_BSLASH);
            if ($urandom_range(0, 1)) begin
                add_byte(bad_esc_chars[$urandom_range(0, bad_esc_chars.len() - 1)]);
            end else begin
                add_byte(C_LC_U);
                repeat ($urandom_range(0, 3)) add_byte(8'h30 + 8'($urandom_range(0, 9)));
                add_byte(bad_hex_chars[$urandom_range(0, bad_hex_chars.len() - 1)]);
            end
            return;
        end
        case ($urandom_range(0, 6))
            0, 1: begin
                c = 8'($urandom);
                if (c == C_QUOTE || c == C_BSLASH) c = 8'h7e;
                add_byte(c);
            end
            2: begin
                add_byte(C_BSLASH);
                add_byte(esc_chars[$urandom_range(0, esc_chars.len() - 1)]);
            end
            3: add_u(16'($urandom));
            4: begin
                // Surrogate pair that joins into one code point.
                add_u(HIGH_FIRST + 16'($urandom_range(0, 'h3ff)));
                add_u(LOW_FIRST + 16'($urandom_range(0, 'h3ff)));
            end
            5: begin
                // High surrogate whose next escape is ruled out at the first or
                // second digit, or is a second high surrogate.
                add_u(HIGH_FIRST + 16'($urandom_range(0, 'h3ff)));
                case ($urandom_range(0, 2))
                    0:       add_u(16'($urandom_range(0, 'hcfff)));
                    1:       add_u(16'hd000 + 16'($urandom_range(0, 'hbff)));
                    default: add_u(16'($urandom_range('he000, 'hffff)));
                endcase
            end
            default: add_u(HIGH_FIRST + 16'($urandom_range(0, 'h7ff)));
        endcase
    endfunction

    // Mostly well-formed documents with random content, some broken, some noise.
    function automatic void build_random_doc();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 2))
            add_byte(lead_chars[$urandom_range(0, lead_chars.len() - 1)]);
        if ($urandom_range(0, 3) == 0) push_text("\"zq\":\"v\",");
        add_key();
        if ($urandom_range(0, 7) == 0) add_byte(C_SPACE);
        if ($urandom_range(0, 11) != 0) add_byte(C_COLON);
        repeat ($urandom_range(0, 2))
            add_byte($urandom_range(0, 1) ? C_SPACE : 8'($urandom_range(9, 13)));
        add_byte($urandom_range(0, 11) == 0 ? 8'h31 : C_QUOTE);
        repeat ($urandom_range(0, 5)) add_piece($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 4) != 0) begin
            add_byte(C_QUOTE);
            repeat ($urandom_range(0, 2))
                add_byte(trail_chars[$urandom_range(0, trail_chars.len() - 1)]);
        end
    endfunction

    // One stretch of random documents under the given idling.
    task automatic run_phase(int n_bytes, int gap_pct, int stall_level, bit squeeze);
        int start;
        send_gap_pct = gap_pct;
        stall_pct    = stall_level;
        start        = bytes_sent;
        if (squeeze) begin
            // Long value while the result side holds off, so the block backs up.
            hold_off_req = 1'b1;
            add_key();
            push_text(":\"");
            repeat (24) add_byte(8'h41 + 8'($urandom_range(0, 25)));
            add_byte(C_QUOTE);
            send_doc();
        end
        while (bytes_sent - start < n_bytes) begin
            build_random_doc();
            send_doc();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed documents with a one-character key.
        load_key(64'h6b, 64'd1);
        // Extreme value bytes and a joined surrogate pair, closed on the final byte.
        push_text("\"k\": \"");
        add_byte(8'hff);
        add_byte(8'h00);
        push_text("\\ud83d\\uDE00\"");
        send_doc();
        // Document ends before the colon.
        push_text("\"k\"x");
        send_doc();
        // High surrogate released by the first digit of the next escape.
        push_text("\"k\":\"\\ud800\\u0041\"z");
        send_doc();
        // Bad escape, then ignored bytes.
        push_text("\"k\":\"\\q}");
        send_doc();
        // A value byte on the final byte gives way to the failure.
        push_text("\"k\":\"a");
        send_doc();
        // Empty key: the pattern is two quotes; the value lacks its quote.
        load_key(64'h0, 64'd0);
        push_text("\"\":\t1");
        send_doc();
        // Length above the maximum saturates; a lone high surrogate at the close.
        load_key('1, 64'd15);
        add_byte(C_QUOTE);
        repeat (8) add_byte(8'hff);
        push_text("\":\"\\udbff\"");
        send_doc();

        // Random documents across several key settings.
        load_key(letters(), {32'($urandom), 28'($urandom), 4'($urandom_range(1, 8))});
        run_phase(20, 25, 25, 1'b0);
        load_key(64'h74786574, 64'd4);
        run_phase(40, 10, 30, 1'b1);
        load_key(64'h0, 64'd8);
        run_phase(15, 30, 0, 1'b0);
        load_key({32'($urandom), 32'($urandom)}, {32'($urandom), 28'($urandom), 4'd1});
        run_phase(15, 0, 30, 1'b0);
        load_key(letters(), {60'd0, 4'($urandom_range(9, 15))});
        run_phase(15, 20, 20, 1'b0);
        load_key(letters(), 64'd0);
        run_phase(10, 15, 15, 1'b0);
        load_key(letters(), {60'd0, 4'($urandom_range(1, 8))});
        run_phase(15, 0, 0, 1'b0);

        drain_results();
        repeat (10) @(negedge i_clk);
        if (sb.words_due.size() != 0)
            sb.report_mismatch($sformatf("%0d words never came out", sb.words_due.size()));
        if (sb.mismatches == 0) begin
            $display("json_string_field_extractor_core_test OK");
        end else begin
            $display("json_string_field_extractor_core_test NOT OK");
        end
        $finish;
    end

endmodule
